>>> sv/fspa_pkg.sv
// Package for the fixed-slot pool allocator.
// Holds field widths, status and register codes, and the cell control struct.
// No dependencies.
package fspa_pkg;

   localparam int OP_W       = 1;
   localparam int LEN_W      = 16;
   localparam int RIDX_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int GIDX_W     = 6;
   localparam int GOFF_W     = 22;
   localparam int DROP_W     = 32;
   localparam int CNT_CFG_W  = 7;
   localparam int SIZE_CFG_W = 16;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [OP_W-1:0] OP_ACQUIRE = 1'b0;
   localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_SLOT_COUNT = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SLOT_SIZE  = 8'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 3'd0,
      ST_TOO_LARGE = 3'd1,
      ST_EXHAUSTED = 3'd2,
      ST_DISABLED  = 3'd3,
      ST_RELEASED  = 3'd4,
      ST_IGNORED   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_SCAN = 2'b10
   } state_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic search_en;
      logic clear;
      logic rel_strobe;
   } cell_ctl_type;

endpackage

>>> sv/fspa_if.sv
// Handshake interfaces for the request, response and register-write channels.
// Depends on fspa_pkg for field widths.
interface fspa_req_if import fspa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic [LEN_W-1:0]        payload_length;
   logic signed [RIDX_W-1:0] release_index;

   modport source (output valid, operation, payload_length, release_index, input ready);
   modport sink   (input valid, operation, payload_length, release_index, output ready);
endinterface

interface fspa_rsp_if import fspa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [GIDX_W-1:0]   granted_index;
   logic [GOFF_W-1:0]   granted_offset;
   logic [DROP_W-1:0]   drop_total;

   modport source (output valid, status, granted_index, granted_offset, drop_total,
                   input ready);
   modport sink   (input valid, status, granted_index, granted_offset, drop_total,
                   output ready);
endinterface

interface fspa_csr_if import fspa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/fspa_cell.sv
// One slot cell: holds the slot's busy bit and the search token position.
// Depends on fspa_pkg for the control struct.
module fspa_cell import fspa_pkg::*; #(
   parameter int IDX_W    = 6,
   parameter int CELL_IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       cell_ctl,
   input  logic [IDX_W-1:0]   rel_index,
   input  logic               token_left,
   output logic               token_right,
   output logic               claim
);

   logic busy_ff;
   logic busy_in;
   logic token_ff;
   logic rel_hit;

   assign claim       = token_ff & ~busy_ff & cell_ctl.search_en;
   // Pass the token on past a busy slot.
   assign token_right = token_ff & busy_ff & cell_ctl.search_en;
   assign rel_hit     = cell_ctl.rel_strobe && (rel_index == IDX_W'(CELL_IDX));

   always_comb begin
      busy_in = busy_ff;
      if (cell_ctl.clear) begin
         busy_in = 1'b0;
      end else if (claim) begin
         busy_in = 1'b1;
      end else if (rel_hit) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         token_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         token_ff <= token_left & ~cell_ctl.clear;
      end
   end

endmodule

>>> sv/fspa_ctrl.sv
// Controller: registers, request decode, scan sequencing, drop counter and
// the two-deep result path. Depends on fspa_pkg and the fspa interfaces.
module fspa_ctrl import fspa_pkg::*; #(
   parameter  int MAX_SLOTS = 64,
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1),
   localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   fspa_req_if.sink              req_bus,
   fspa_rsp_if.source            rsp_bus,
   fspa_csr_if.sink              csr_bus,
   output cell_ctl_type          cell_ctl,
   output logic [IDX_W-1:0]      rel_index,
   output logic                  launch,
   input  logic [MAX_SLOTS-1:0]  claim_vec,
   input  logic                  tail_token
);

   logic [CNT_CFG_W-1:0]  slot_cnt_ff;
   logic [SIZE_CFG_W-1:0] slot_size_ff;
   logic [DROP_W-1:0]     drop_ff;
   logic [DROP_W-1:0]     drop_in;
   state_type             state_ff;
   state_type             state_in;
   logic [CNT_W-1:0]      scan_ff;
   logic [CNT_W-1:0]      scan_in;
   logic [GOFF_W-1:0]     off_ff;
   logic [GOFF_W-1:0]     off_in;

   logic                  pend_valid_ff;
   status_type            pend_status_ff;
   logic [GIDX_W-1:0]     pend_gidx_ff;
   logic [GOFF_W-1:0]     pend_goff_ff;
   logic [DROP_W-1:0]     pend_drop_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [GIDX_W-1:0]     rsp_gidx_ff;
   logic [GOFF_W-1:0]     rsp_goff_ff;
   logic [DROP_W-1:0]     rsp_drop_ff;

   logic [CNT_W-1:0]      slots_eff;
   logic                  pool_off;
   logic                  req_fire;
   logic                  csr_fire;
   logic                  rel_ok;
   logic                  len_big;
   logic                  any_claim;
   logic                  out_load;
   logic                  produce;
   status_type            res_status;
   logic [GIDX_W-1:0]     res_gidx;
   logic [GOFF_W-1:0]     res_goff;

   // Effective slot count: zero when disabled, saturated to the pool size.
   always_comb begin
      if (slot_cnt_ff == '0 || slot_size_ff == '0) begin
         slots_eff = '0;
      end else if (32'(slot_cnt_ff) > 32'(MAX_SLOTS)) begin
         slots_eff = CNT_W'(MAX_SLOTS);
      end else begin
         slots_eff = CNT_W'(slot_cnt_ff);
      end
   end

   assign pool_off      = (slots_eff == '0);
   assign req_bus.ready = !reset && (state_ff == FSM_IDLE) && !pend_valid_ff;
   assign csr_bus.ready = !reset;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;
   assign rel_ok        = !req_bus.release_index[RIDX_W-1] &&
                          (32'(req_bus.release_index[RIDX_W-2:0]) < 32'(slots_eff));
   assign rel_index     = IDX_W'(req_bus.release_index[RIDX_W-2:0]);
   assign len_big       = req_bus.payload_length > slot_size_ff;
   assign any_claim     = |claim_vec;

   assign cell_ctl.search_en  = (state_ff == FSM_SCAN) && (scan_ff < slots_eff);
   assign cell_ctl.clear      = csr_fire &&
                                (csr_bus.index == REG_SLOT_COUNT ||
                                 csr_bus.index == REG_SLOT_SIZE);
   assign cell_ctl.rel_strobe = req_fire && (req_bus.operation == OP_RELEASE) && rel_ok;
   assign launch              = req_fire && (req_bus.operation == OP_ACQUIRE) &&
                                !pool_off && !len_big;

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      off_in     = off_ff;
      drop_in    = drop_ff;
      produce    = 1'b0;
      res_status = ST_GRANTED;
      res_gidx   = '0;
      res_goff   = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               if (req_bus.operation == OP_RELEASE) begin
                  produce    = 1'b1;
                  res_status = rel_ok ? ST_RELEASED : ST_IGNORED;
               end else if (pool_off) begin
                  produce    = 1'b1;
                  res_status = ST_DISABLED;
               end else if (len_big) begin
                  produce    = 1'b1;
                  res_status = ST_TOO_LARGE;
               end else begin
                  state_in = FSM_SCAN;
                  scan_in  = '0;
                  off_in   = '0;
               end
            end
         end
         FSM_SCAN: begin
            if (any_claim) begin
               produce    = 1'b1;
               res_status = ST_GRANTED;
               res_gidx   = GIDX_W'(scan_ff);
               res_goff   = off_ff;
               state_in   = FSM_IDLE;
            end else if (!cell_ctl.search_en || tail_token) begin
               // Token ran past the last slot in use.
               produce    = 1'b1;
               res_status = ST_EXHAUSTED;
               drop_in    = drop_ff + 1'b1;
               state_in   = FSM_IDLE;
            end else begin
               // Track the token: index and offset advance with it.
               scan_in = scan_ff + 1'b1;
               off_in  = off_ff + GOFF_W'(slot_size_ff);
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
      if (cell_ctl.clear) begin
         drop_in = '0;
      end
   end

   assign out_load = pend_valid_ff && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         slot_cnt_ff   <= '0;
         slot_size_ff  <= '0;
         drop_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         drop_ff       <= drop_in;
         pend_valid_ff <= produce | (pend_valid_ff & ~out_load);
         rsp_valid_ff  <= out_load | (rsp_valid_ff & ~rsp_bus.ready);
         if (csr_fire) begin
            case (csr_bus.index)
               REG_SLOT_COUNT: slot_cnt_ff  <= csr_bus.data[CNT_CFG_W-1:0];
               REG_SLOT_SIZE:  slot_size_ff <= csr_bus.data[SIZE_CFG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      off_ff  <= off_in;
      if (produce) begin
         pend_status_ff <= res_status;
         pend_gidx_ff   <= res_gidx;
         pend_goff_ff   <= res_goff;
         pend_drop_ff   <= drop_in;
      end
      if (out_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_gidx_ff   <= pend_gidx_ff;
         rsp_goff_ff   <= pend_goff_ff;
         rsp_drop_ff   <= pend_drop_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.granted_index  = rsp_gidx_ff;
   assign rsp_bus.granted_offset = rsp_goff_ff;
   assign rsp_bus.drop_total     = rsp_drop_ff;

endmodule

>>> sv/fixed_slot_pool_allocator_top.sv
// Fixed-slot pool allocator: a row of slot cells with a search token, plus controller.
// A release or refused acquire is decided at once; a grant or exhaustion follows the token
// scan, one cell per cycle. Every result passes the pending stage, then the response register.
// One item at a time: a new request is taken once the result leaves the pending stage.
// Sync active-high reset frees all slots, zeroes registers and drops, holds ready low.
module fixed_slot_pool_allocator_top import fspa_pkg::*; #(
   parameter int MAX_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   fspa_req_if.sink    req_bus,
   fspa_rsp_if.source  rsp_bus,
   fspa_csr_if.sink    csr_bus
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   cell_ctl_type         cell_ctl;
   logic [IDX_W-1:0]     rel_index;
   logic                 launch;
   logic [MAX_SLOTS-1:0] claim_vec;
   logic [MAX_SLOTS:0]   token_chain;

   assign token_chain[0] = launch;

   fspa_ctrl #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .cell_ctl   (cell_ctl),
      .rel_index  (rel_index),
      .launch     (launch),
      .claim_vec  (claim_vec),
      .tail_token (token_chain[MAX_SLOTS])
   );

   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      fspa_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_ctl    (cell_ctl),
         .rel_index   (rel_index),
         .token_left  (token_chain[i]),
         .token_right (token_chain[i+1]),
         .claim       (claim_vec[i])
      );
   end

endmodule

>>> sv/fspa_checker.sv
// Port-level checks for the pool allocator, bound to the top level.
// Depends on fspa_pkg for status codes.
module fspa_checker import fspa_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] status,
   input logic [GIDX_W-1:0]   granted_index,
   input logic [GOFF_W-1:0]   granted_offset,
   input logic [DROP_W-1:0]   drop_total
);

   logic [1:0] outstanding_ff;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 2'(req_fire) - 2'(rsp_fire);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
         $stable(granted_index) && $stable(granted_offset) && $stable(drop_total))
      else $error("response changed while stalled");

   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ST_GRANTED) |-> granted_index == '0 && granted_offset == '0)
      else $error("slot fields set on a non-grant result");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("response without an accepted item");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("second item taken before the first finished");

endmodule

bind fixed_slot_pool_allocator_top fspa_checker u_fspa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .status         (rsp_bus.status),
   .granted_index  (rsp_bus.granted_index),
   .granted_offset (rsp_bus.granted_offset),
   .drop_total     (rsp_bus.drop_total)
);

>>> sim/tb_fixed_slot_pool_allocator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_slot_pool_allocator_top: directed table, then random phases.
// Depends on fspa_pkg, the fspa_*_if interfaces and the allocator RTL.
module tb_fixed_slot_pool_allocator_top;
   import fspa_pkg::*;

   localparam int POOL_SLOTS  = 64;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 95;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [LEN_W-1:0]         payload_length;
      logic signed [RIDX_W-1:0] release_index;
   } pool_req_type;

   typedef struct packed {
      status_type          status;
      logic [GIDX_W-1:0]   granted_index;
      logic [GOFF_W-1:0]   granted_offset;
      logic [DROP_W-1:0]   drop_total;
   } pool_rsp_type;

   typedef struct packed {
      bit                    is_csr;
      logic [CSR_ADDR_W-1:0] csr_index;
      logic [CSR_DATA_W-1:0] csr_data;
      pool_req_type          req;
      bit                    typed;
      pool_rsp_type          rsp;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fspa_req_if req_if ();
   fspa_rsp_if rsp_if ();
   fspa_csr_if csr_if ();

   fixed_slot_pool_allocator_top #(.MAX_SLOTS(POOL_SLOTS)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always #6 clock = ~clock;

   // Pool image kept by the testbench
   logic [CNT_CFG_W-1:0]  cfg_count;
   logic [SIZE_CFG_W-1:0] cfg_size;
   logic [POOL_SLOTS-1:0] slot_busy;
   logic [DROP_W-1:0]     drop_count;

   pool_rsp_type expected_answers[$];
   plan_row_type directed_plan[$];
   int           answer_mismatches = 0;
   int           status_tally[6];
   int           requests_sent = 0;
   int           csr_writes = 0;
   int           burst_left = 0;
   bit           hold_request = 1'b0;

   function automatic int usable_slots();
      if (cfg_count == 0 || cfg_size == 0) return 0;
      if (cfg_count > POOL_SLOTS) return POOL_SLOTS;
      return cfg_count;
   endfunction

   function automatic void apply_register(input logic [CSR_ADDR_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] val);
      if (idx == REG_SLOT_COUNT) cfg_count = val[CNT_CFG_W-1:0];
      else if (idx == REG_SLOT_SIZE) cfg_size = val;
      else return;
      slot_busy  = '0;
      drop_count = '0;
   endfunction

   // Advance the pool image by one request and return the answer it gives.
   function automatic pool_rsp_type predict_pool_answer(input pool_req_type r);
      pool_rsp_type res;
      int           slots;
      int           ridx;
      logic [31:0]  slot_no;
      logic [31:0]  off_full;
      bit           found;
      res = '0;
      slots = usable_slots();
      if (r.operation == OP_ACQUIRE) begin
         if (slots == 0) begin
            res.status = ST_DISABLED;
         end else if (r.payload_length > cfg_size) begin
            res.status = ST_TOO_LARGE;
         end else begin
            found = 1'b0;
            for (slot_no = 0; slot_no < slots; slot_no++) begin
               if (!found && !slot_busy[slot_no]) begin
                  found = 1'b1;
                  slot_busy[slot_no] = 1'b1;
                  off_full = slot_no * cfg_size;
                  res.granted_index  = slot_no[GIDX_W-1:0];
                  res.granted_offset = off_full[GOFF_W-1:0];
               end
            end
            if (found) begin
               res.status = ST_GRANTED;
            end else begin
               res.status = ST_EXHAUSTED;
               drop_count = drop_count + 1;
            end
         end
      end else begin
         ridx = $signed(r.release_index);
         if (ridx >= 0 && ridx < slots) begin
            slot_busy[ridx] = 1'b0;
            res.status = ST_RELEASED;
         end else begin
            res.status = ST_IGNORED;
         end
      end
      res.drop_total = drop_count;
      return res;
   endfunction

   function automatic plan_row_type row_csr(input logic [CSR_ADDR_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      plan_row_type row;
      row = '0;
      row.is_csr    = 1'b1;
      row.csr_index = idx;
      row.csr_data  = val;
      return row;
   endfunction

   function automatic plan_row_type row_req(input logic [OP_W-1:0] op,
                                            input logic [LEN_W-1:0] len,
                                            input logic [RIDX_W-1:0] ridx);
      plan_row_type row;
      row = '0;
      row.req.operation      = op;
      row.req.payload_length = len;
      row.req.release_index  = ridx;
      return row;
   endfunction

   function automatic plan_row_type row_chk(input logic [OP_W-1:0] op,
                                            input logic [LEN_W-1:0] len,
                                            input logic [RIDX_W-1:0] ridx,
                                            input status_type st,
                                            input logic [GIDX_W-1:0] gidx,
                                            input logic [GOFF_W-1:0] goff,
                                            input logic [DROP_W-1:0] drops);
      plan_row_type row;
      row = row_req(op, len, ridx);
      row.typed              = 1'b1;
      row.rsp.status         = st;
      row.rsp.granted_index  = gidx;
      row.rsp.granted_offset = goff;
      row.rsp.drop_total     = drops;
      return row;
   endfunction

   // Random request shaped by the current pool image.
   function automatic pool_req_type draw_request(input bit fill_only);
      pool_req_type r;
      logic [31:0]  rnd;
      int           slots;
      int           roll;
      int           pick;
      int           k;
      int           cand;
      bit           found;
      rnd = $urandom;
      r.payload_length = rnd[15:0];
      r.release_index  = rnd[31:16];
      slots = usable_slots();
      roll = $urandom_range(0, 99);
      if (fill_only || roll < 55) begin
         r.operation = OP_ACQUIRE;
         roll = $urandom_range(0, 99);
         if (fill_only || roll < 75) begin
            rnd = $urandom_range(0, cfg_size);
            r.payload_length = rnd[15:0];
         end else if (roll < 87) begin
            r.payload_length = cfg_size;
         end
      end else begin
         r.operation = OP_RELEASE;
         roll = $urandom_range(0, 99);
         if (roll < 70 && slots > 0 && slot_busy != '0) begin
            pick  = $urandom_range(0, slots - 1);
            found = 1'b0;
            for (k = 0; k < slots; k++) begin
               cand = (pick + k) % slots;
               if (!found && slot_busy[cand]) begin
                  found = 1'b1;
                  r.release_index = RIDX_W'(cand);
               end
            end
         end else if (roll < 85) begin
            rnd = $urandom_range(0, slots + 1);
            r.release_index = rnd[15:0];
         end
      end
      return r;
   endfunction

   // Offer one request in bursts with random gaps; record the answer once taken.
   task automatic offer_request(input pool_req_type r, input bit typed,
                                input pool_rsp_type typed_rsp);
      pool_rsp_type exp;
      int           gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 7)) inside
            [0:2]:   gap = 0;
            3:       gap = $urandom_range(20, 70);
            default: gap = $urandom_range(1, 10);
         endcase
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.operation      <= r.operation;
      req_if.payload_length <= r.payload_length;
      req_if.release_index  <= r.release_index;
      req_if.valid          <= 1'b1;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      exp = predict_pool_answer(r);
      if (typed) exp = typed_rsp;
      expected_answers.push_back(exp);
      status_tally[exp.status]++;
      requests_sent++;
   endtask

   // Drop valid and wait for every outstanding answer.
   task automatic settle_pool();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_if.index <= idx;
      csr_if.data  <= val;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
      apply_register(idx, val);
      csr_writes++;
      @(posedge clock);
   endtask

   // Response side: stall pattern of its own, plus a long hold on request.
   initial begin : rsp_pace
      int hold_left;
      int mode_left;
      int rx_mode;
      hold_left = 0;
      mode_left = 0;
      rx_mode   = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (rx_mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : answer_check
      pool_rsp_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_answers.size() == 0) begin
            $error("unexpected item: status %0d index %0d offset %0d drops %0d",
                   rsp_if.status, rsp_if.granted_index, rsp_if.granted_offset,
                   rsp_if.drop_total);
            answer_mismatches++;
         end else begin
            exp = expected_answers.pop_front();
            if (rsp_if.status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, rsp_if.status);
               answer_mismatches++;
            end
            if (rsp_if.granted_index !== exp.granted_index) begin
               $error("granted_index: expected %0d, got %0d",
                      exp.granted_index, rsp_if.granted_index);
               answer_mismatches++;
            end
            if (rsp_if.granted_offset !== exp.granted_offset) begin
               $error("granted_offset: expected %0d, got %0d",
                      exp.granted_offset, rsp_if.granted_offset);
               answer_mismatches++;
            end
            if (rsp_if.drop_total !== exp.drop_total) begin
               $error("drop_total: expected %0d, got %0d", exp.drop_total, rsp_if.drop_total);
               answer_mismatches++;
            end
         end
      end
   end

   initial begin : run_limit
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      plan_row_type          row;
      pool_req_type          r;
      logic [31:0]           rnd;
      logic [CSR_DATA_W-1:0] count_raw;
      logic [CSR_DATA_W-1:0] size_raw;
      int                    n;
      int                    ph;
      int                    fill_len;

      req_if.valid          <= 1'b0;
      req_if.operation      <= OP_ACQUIRE;
      req_if.payload_length <= '0;
      req_if.release_index  <= '0;
      csr_if.valid          <= 1'b0;
      csr_if.index          <= REG_SLOT_COUNT;
      csr_if.data           <= '0;
      cfg_count  = '0;
      cfg_size   = '0;
      slot_busy  = '0;
      drop_count = '0;
      for (n = 0; n < 6; n++) status_tally[n] = 0;

      // Pool starts disabled, then a three-slot pool of 100 bytes
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd0, 16'd0, ST_DISABLED, 0, 0, 0));
      directed_plan.push_back(row_chk(OP_RELEASE, 16'd0, 16'd0, ST_IGNORED, 0, 0, 0));
      directed_plan.push_back(row_csr(REG_SLOT_COUNT, 16'd3));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd5, 16'd0, ST_DISABLED, 0, 0, 0));
      directed_plan.push_back(row_csr(REG_SLOT_SIZE, 16'd100));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd100, 16'd0, ST_GRANTED, 0, 0, 0));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd101, 16'd0, ST_TOO_LARGE, 0, 0, 0));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd0, 16'hFFFF, ST_GRANTED, 1, 100, 0));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'hFFFF, 16'd0, ST_TOO_LARGE, 0, 0, 0));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd50, 16'd0, ST_GRANTED, 2, 200, 0));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd1, 16'd0, ST_EXHAUSTED, 0, 0, 1));
      directed_plan.push_back(row_chk(OP_RELEASE, 16'hFFFF, 16'd1, ST_RELEASED, 0, 0, 1));
      // releasing a slot that is already free still answers released
      directed_plan.push_back(row_chk(OP_RELEASE, 16'd0, 16'd1, ST_RELEASED, 0, 0, 1));
      directed_plan.push_back(row_chk(OP_RELEASE, 16'd0, 16'hFFFF, ST_IGNORED, 0, 0, 1));
      directed_plan.push_back(row_chk(OP_RELEASE, 16'd0, 16'd3, ST_IGNORED, 0, 0, 1));
      directed_plan.push_back(row_chk(OP_RELEASE, 16'd0, 16'h8000, ST_IGNORED, 0, 0, 1));
      directed_plan.push_back(row_chk(OP_RELEASE, 16'd0, 16'h7FFF, ST_IGNORED, 0, 0, 1));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd7, 16'd0, ST_GRANTED, 1, 100, 1));
      // unknown register: no clear, pool stays full
      directed_plan.push_back(row_csr(8'd2, 16'hFFFF));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd7, 16'd0, ST_EXHAUSTED, 0, 0, 2));
      directed_plan.push_back(row_csr(REG_SLOT_COUNT, 16'd0));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd0, 16'd0, ST_DISABLED, 0, 0, 0));
      directed_plan.push_back(row_chk(OP_RELEASE, 16'd0, 16'd0, ST_IGNORED, 0, 0, 0));
      // count 65 after masking saturates to the full pool
      directed_plan.push_back(row_csr(REG_SLOT_COUNT, 16'h00C1));
      directed_plan.push_back(row_csr(REG_SLOT_SIZE, 16'hFFFF));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'hFFFF, 16'd0, ST_GRANTED, 0, 0, 0));
      directed_plan.push_back(row_req(OP_RELEASE, 16'd0, 16'd64));
      directed_plan.push_back(row_req(OP_RELEASE, 16'd0, 16'd63));
      directed_plan.push_back(row_chk(OP_ACQUIRE, 16'd0, 16'd0, ST_GRANTED, 1, 22'd65535, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[n]) begin
         row = directed_plan[n];
         if (row.is_csr) begin
            settle_pool();
            write_register(row.csr_index, row.csr_data);
         end else begin
            offer_request(row.req, row.typed, row.rsp);
         end
      end

      for (ph = 0; ph < PHASES; ph++) begin
         rnd = $urandom;
         case (ph)
            0:       begin count_raw = 16'd1;     size_raw = 16'd1;            end
            1:       begin count_raw = 16'd64;    size_raw = 16'hFFFF;         end
            2:       begin count_raw = 16'hFF7F;  size_raw = rnd[15:0] | 16'd1; end
            3:       begin count_raw = 16'd4;     size_raw = 16'hFFFF;         end
            4:       begin count_raw = rnd[15:0]; size_raw = 16'd0;            end
            6:       begin count_raw = 16'd2;     size_raw = 16'd1;            end
            7:       begin count_raw = 16'd64;    size_raw = 16'd1;            end
            8:       begin count_raw = 16'd40;    size_raw = rnd[31:16];       end
            9:       begin count_raw = 16'd8;     size_raw = 16'd300;          end
            10:      begin count_raw = 16'h007F;  size_raw = 16'hFFFF;         end
            default: begin count_raw = rnd[15:0]; size_raw = rnd[31:16];       end
         endcase
         settle_pool();
         if (ph % 2 == 1) begin
            write_register(REG_SLOT_COUNT, count_raw);
            write_register(REG_SLOT_SIZE, size_raw);
         end else begin
            write_register(REG_SLOT_SIZE, size_raw);
            write_register(REG_SLOT_COUNT, count_raw);
         end
         rnd = $urandom;
         write_register(CSR_ADDR_W'($urandom_range(2, 255)), rnd[15:0]);

         // fill the pool past exhaustion first, then mix
         fill_len = usable_slots() + 3;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 3 && n == 10) hold_request = 1'b1;
            if (n == 50) settle_pool();
            r = draw_request(n < fill_len);
            offer_request(r, 1'b0, '0);
         end
      end

      settle_pool();
      repeat (80) @(posedge clock);

      $display("Ran %0d requests and %0d register writes; %0d random pool setups.",
               requests_sent, csr_writes, PHASES);
      $display("Answers: %0d granted, %0d too large, %0d exhausted,",
               status_tally[ST_GRANTED], status_tally[ST_TOO_LARGE],
               status_tally[ST_EXHAUSTED]);
      $display("         %0d disabled, %0d released, %0d ignored.",
               status_tally[ST_DISABLED], status_tally[ST_RELEASED],
               status_tally[ST_IGNORED]);
      if (answer_mismatches == 0 && expected_answers.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
